// ----- hw/rtl/pstl_pkg.sv -----
// shared types and constants of the per-source failure tracker
// no dependencies; imported by every module of the block but pstl_ram
package pstl_pkg;

    localparam int DEF_ENTRIES = 256;

    localparam int KEY_W    = 64;
    localparam int TIME_W   = 64;
    localparam int COUNT_W  = 32;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 96;

    localparam logic [TIME_W-1:0]  WINDOW_RESET    = 64'd60_000_000_000;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 32'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 32'hFFFF_FFFF;

    // opcodes carried on s_tuser
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  first_seen;
        logic [TIME_W-1:0]  last_seen;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ARM,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic write;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic match;
        logic scan_end;
        logic out_busy;
    } status_t;

endpackage

// ----- hw/rtl/pstl_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module pstl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/pstl_ctrl.sv -----
// controller state machine: accept, scan, table update, result hand-off
// depends on pstl_pkg
module pstl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output pstl_pkg::cmd_t   cmd,
    input  pstl_pkg::status_t sts
);

    import pstl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_ARM;
                end
            end
            ST_ARM:
            begin
                // a query waits until the output register can take its result
                if (!sts.is_query || !sts.out_busy)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.match || sts.scan_end)
                begin
                    state_next = sts.is_query ? ST_IDLE : ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_ARM:
            begin
                cmd = '0;
            end
            ST_SCAN:
            begin
                cmd.scan     = 1'b1;
                cmd.out_load = sts.is_query && (sts.match || sts.scan_end);
            end
            ST_UPDATE:
            begin
                cmd.write = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/pstl_dp.sv -----
// datapath: item and config registers, table ram, scan pipeline, output register
// depends on pstl_pkg and pstl_ram
module pstl_dp #(
    parameter int ENTRIES = pstl_pkg::DEF_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pstl_pkg::cmd_t                  cmd,
    output pstl_pkg::status_t               sts,
    input  logic                            s_tuser,
    input  logic [pstl_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_tuser,
    output logic [pstl_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [pstl_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [pstl_pkg::CFG_W-1:0]      cfg_wdata
);

    import pstl_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int ENT_W = $bits(entry_t);

    // configuration
    logic [TIME_W-1:0]  window_reg;
    logic [COUNT_W-1:0] thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            thresh_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WINDOW:    window_reg <= cfg_wdata;
                REG_THRESHOLD: thresh_reg <= cfg_wdata[COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // item registers
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] time_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= s_tuser;
            key_reg  <= s_tdata[KEY_W-1:0];
            time_reg <= s_tdata[KEY_W +: TIME_W];
        end
    end

    // scan pipeline: issue a read, compare its data in the following cycle
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic [CNT_W-1:0] iss_reg;
    logic [CNT_W-1:0] iss_next;
    logic             cmp_vld_reg;
    logic             cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             issue;
    logic             full;
    entry_t           rd_entry;
    logic [ENT_W-1:0] rd_data;

    assign full  = (used_reg == CNT_W'(ENTRIES));
    assign issue = cmd.scan && (iss_reg < used_reg);
    assign iss_next     = cmd.load ? '0 : (issue ? iss_reg + CNT_W'(1) : iss_reg);
    assign cmp_vld_next = cmd.load ? 1'b0 : issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            used_reg    <= '0;
        end
        else
        begin
            iss_reg     <= iss_next;
            cmp_vld_reg <= cmp_vld_next;
            used_reg    <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= iss_reg[IDX_W-1:0];
    end

    assign rd_entry = entry_t'(rd_data);

    // compare stage
    logic [TIME_W-1:0] age;
    logic              key_eq;
    logic              qualify;
    logic              is_last;
    logic              match;

    assign age     = time_reg - rd_entry.first_seen;
    assign key_eq  = (rd_entry.key == key_reg);
    assign qualify = (age <= window_reg) && (rd_entry.count > thresh_reg);
    assign match   = cmd.scan && cmp_vld_reg && ((op_reg == OP_QUERY) ? qualify : key_eq);
    assign is_last = cmp_vld_reg && ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == used_reg);

    assign sts.is_query = (op_reg == OP_QUERY);
    assign sts.match    = match;
    assign sts.scan_end = (used_reg == '0) || is_last;
    assign sts.out_busy = m_tvalid && !m_tready;

    // hit capture and least-recently-seen tracking (strict less keeps lowest index)
    logic              hit_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    entry_t            hit_entry_reg;
    logic [TIME_W-1:0] min_seen_reg;
    logic [IDX_W-1:0]  min_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            hit_found_reg <= 1'b0;
        end
        else if (match)
        begin
            hit_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (match)
        begin
            hit_idx_reg   <= cmp_idx_reg;
            hit_entry_reg <= rd_entry;
        end
        if (cmd.scan && cmp_vld_reg &&
            ((cmp_idx_reg == '0) || (rd_entry.last_seen < min_seen_reg)))
        begin
            min_seen_reg <= rd_entry.last_seen;
            min_idx_reg  <= cmp_idx_reg;
        end
    end

    // table update
    entry_t           wr_entry;
    logic [IDX_W-1:0] wr_idx;

    always_comb
    begin
        wr_entry  = hit_entry_reg;
        wr_idx    = hit_idx_reg;
        used_next = used_reg;
        if (hit_found_reg)
        begin
            if (hit_entry_reg.count != COUNT_MAX)
            begin
                wr_entry.count = hit_entry_reg.count + COUNT_W'(1);
            end
            wr_entry.last_seen = time_reg;
        end
        else
        begin
            wr_entry.key        = key_reg;
            wr_entry.count      = COUNT_W'(1);
            wr_entry.first_seen = time_reg;
            wr_entry.last_seen  = time_reg;
            wr_idx              = full ? min_idx_reg : used_reg[IDX_W-1:0];
            if (cmd.write && !full)
            begin
                used_next = used_reg + CNT_W'(1);
            end
        end
    end

    pstl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .raddr (iss_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    // output register
    logic               out_vld_reg;
    logic               det_reg;
    logic [KEY_W-1:0]   src_reg;
    logic [COUNT_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            det_reg <= match;
            src_reg <= match ? rd_entry.key : '0;
            cnt_reg <= match ? rd_entry.count : '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = det_reg;
    assign m_tdata  = {cnt_reg, src_reg};

    // fill count moves only by one, and only on a table write
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |->
            ($past(cmd.write) && (used_reg == $past(used_reg) + CNT_W'(1))))
        else $error("fill count changed without a table write");

    // a result is never loaded over one that is still waiting
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_vld_reg || m_tready))
        else $error("result register overwritten");

    // after any table write the table holds at least one entry
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> (used_reg != '0))
        else $error("table empty after write");

    // a record hit refers to an entry already filled
    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write && hit_found_reg) |-> (CNT_W'(hit_idx_reg) < used_reg))
        else $error("hit index beyond filled entries");

endmodule

// ----- hw/rtl/per_source_failure_tracker_lru_core.sv -----
// top level of the per-source failure tracker with least-recently-seen eviction
// depends on pstl_pkg, pstl_ctrl, pstl_dp (which holds pstl_ram)
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tuser: opcode; s_tdata: key, time
//  m_*      | out       | m_tvalid/m_tready  | m_tuser: detected; m_tdata: source, count
//  cfg_*    | in        | cfg_we             | cfg_addr: register index; cfg_wdata: value
//
// one item at a time; the table ram has one read port and the scan reads one
// entry per cycle, stopping early when an entry matches; otherwise a scan covers
// all used entries, used being the number of filled entries
// reset clears the fill count, the state machine and the result register; the
// table contents are not cleared, entries beyond the fill count are never read
// a query does not start its scan while an earlier result is still held on m_*;
// records proceed regardless of the output side
module per_source_failure_tracker_lru_core #(
    parameter int TABLE_ENTRIES = pstl_pkg::DEF_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_tuser,   // [0] opcode
    input  logic [pstl_pkg::S_DATA_W-1:0]   s_tdata,   // [63:0] source_key, [127:64] time_ns
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_tuser,   // [0] detected
    output logic [pstl_pkg::M_DATA_W-1:0]   m_tdata,   // [63:0] hit_source, [95:64] hit_count
    // configuration write port
    input  logic                            cfg_we,
    input  logic [pstl_pkg::CFG_IDX_W-1:0]  cfg_addr,  // 0 window_length, 1 count_threshold
    input  logic [pstl_pkg::CFG_W-1:0]      cfg_wdata
);

    import pstl_pkg::*;

    // command and status between controller and datapath
    cmd_t    cmd;
    status_t sts;

    pstl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // table, scan pipeline and result register
    pstl_dp #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ----- tb/tb_pstl_checker.sv -----
// checker for the per-source failure tracker: watches the item, result and register channels,
// keeps its own copy of the source table and compares every result with its prediction
// depends on pstl_pkg
module tb_pstl_checker #(
    parameter int TABLE_ENTRIES = pstl_pkg::DEF_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            s_tuser,   // [0] opcode
    input  logic [pstl_pkg::S_DATA_W-1:0]   s_tdata,   // [63:0] source_key, [127:64] time_ns
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            m_tuser,   // [0] detected
    input  logic [pstl_pkg::M_DATA_W-1:0]   m_tdata,   // [63:0] hit_source, [95:64] hit_count
    input  logic                            cfg_we,
    input  logic [pstl_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [pstl_pkg::CFG_W-1:0]      cfg_wdata,
    output int                              pending,
    output int                              errors,
    output int                              checked,
    output int                              detections
);
    timeunit 1ns;
    timeprecision 1ps;
    import pstl_pkg::*;

    typedef struct packed {
        logic               detected;
        logic [KEY_W-1:0]   source;
        logic [COUNT_W-1:0] count;
    } offender_t;

    logic [KEY_W-1:0]   src_key   [TABLE_ENTRIES];
    logic [COUNT_W-1:0] src_count [TABLE_ENTRIES];
    logic [TIME_W-1:0]  src_first [TABLE_ENTRIES];
    logic [TIME_W-1:0]  src_last  [TABLE_ENTRIES];
    int                 filled = 0;

    logic [TIME_W-1:0]  window    = WINDOW_RESET;
    logic [COUNT_W-1:0] threshold = THRESHOLD_RESET;

    offender_t          pending_verdicts [$];

    initial
    begin
        pending    = 0;
        errors     = 0;
        checked    = 0;
        detections = 0;
    end

    task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        if (errors <= 100)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        else if (errors == 101)
            $display("%0t ns: further mismatches counted but not shown", $time);
    endtask

    // one failure on a source: bump a hit, else take a free slot or the least recently seen one
    task automatic note_failure(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] t);
        int                i;
        int                slot;
        bit                found;
        logic [TIME_W-1:0] oldest;
        found = 0;
        for (i = 0; i < filled; i++)
        begin
            if (!found && src_key[i] == key)
            begin
                if (src_count[i] != COUNT_MAX)
                    src_count[i] = src_count[i] + COUNT_W'(1);
                src_last[i] = t;
                found = 1;
            end
        end
        if (!found)
        begin
            if (filled < TABLE_ENTRIES)
            begin
                slot = filled;
                filled++;
            end
            else
            begin
                // strict compare keeps the lowest index on equal times
                slot = 0;
                oldest = src_last[0];
                for (i = 1; i < TABLE_ENTRIES; i++)
                begin
                    if (src_last[i] < oldest)
                    begin
                        oldest = src_last[i];
                        slot = i;
                    end
                end
            end
            src_key[slot]   = key;
            src_count[slot] = COUNT_W'(1);
            src_first[slot] = t;
            src_last[slot]  = t;
        end
    endtask

    // first entry in index order that is young enough and frequent enough
    function automatic offender_t find_offender(input logic [TIME_W-1:0] now);
        offender_t         res;
        int                i;
        logic [TIME_W-1:0] age;
        res = '0;
        for (i = 0; i < filled; i++)
        begin
            age = now - src_first[i];
            if (!res.detected && age <= window && src_count[i] > threshold)
            begin
                res.detected = 1'b1;
                res.source   = src_key[i];
                res.count    = src_count[i];
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        offender_t want;
        if (!rst_n)
        begin
            window    = WINDOW_RESET;
            threshold = THRESHOLD_RESET;
            filled    = 0;
            pending_verdicts.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_WINDOW)
                    window = cfg_wdata;
                else if (cfg_addr == REG_THRESHOLD)
                    threshold = cfg_wdata[COUNT_W-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_QUERY)
                    pending_verdicts.push_back(find_offender(s_tdata[KEY_W +: TIME_W]));
                else
                    note_failure(s_tdata[0 +: KEY_W], s_tdata[KEY_W +: TIME_W]);
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_verdicts.size() == 0)
                    flag("result with no query waiting", m_tdata[0 +: KEY_W], 64'd0);
                else
                begin
                    want = pending_verdicts.pop_front();
                    checked++;
                    if (want.detected)
                        detections++;
                    if (m_tuser !== want.detected)
                        flag("detected", 64'(m_tuser), 64'(want.detected));
                    if (m_tdata[0 +: KEY_W] !== want.source)
                        flag("hit_source", m_tdata[0 +: KEY_W], want.source);
                    if (m_tdata[KEY_W +: COUNT_W] !== want.count)
                        flag("hit_count", 64'(m_tdata[KEY_W +: COUNT_W]), 64'(want.count));
                end
            end
            pending <= pending_verdicts.size();
        end
    end

endmodule

// ----- tb/tb_per_source_failure_tracker_lru_core.sv -----
// top of the failure tracker testbench: clock, reset, item and register stimulus, verdict
// depends on pstl_pkg, per_source_failure_tracker_lru_core and tb_pstl_checker
module tb_per_source_failure_tracker_lru_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pstl_pkg::*;

    localparam int ENTRIES = DEF_ENTRIES;
    // a trailing record may still scan the whole table while nothing is expected;
    // the settle time leaves ample margin for that
    localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic                  s_tuser   = OP_RECORD;   // [0] opcode
    logic [S_DATA_W-1:0]   s_tdata   = '0;          // [63:0] source_key, [127:64] time_ns
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  m_tuser;                 // [0] detected
    logic [M_DATA_W-1:0]   m_tdata;                 // [63:0] hit_source, [95:64] hit_count
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = REG_WINDOW;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int pending;
    int errors;
    int checked;
    int detections;

    // bookkeeping for the summary
    int items_sent = 0;
    int queries_sent = 0;
    int reg_writes = 0;

    // no idling on either side while set
    bit calm = 1'b0;

    logic [63:0] now_ns = '0;
    logic [63:0] pool [16];

    // per-phase register settings, extremes included
    logic [63:0] win_set [8] = '{WINDOW_RESET, 64'd5000, 64'd0, ALL_ONES,
                                 64'd20000, 64'd1000, WINDOW_RESET, 64'd50000};
    logic [31:0] thr_set [8] = '{32'd5, 32'd2, 32'd0, 32'd1,
                                 32'd3, 32'd0, COUNT_MAX, 32'd4};

    per_source_failure_tracker_lru_core #(
        .TABLE_ENTRIES (ENTRIES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    tb_pstl_checker #(
        .TABLE_ENTRIES (ENTRIES)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .errors     (errors),
        .checked    (checked),
        .detections (detections)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run (full table, long stalls, long gaps)
    initial
    begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // idle cycles before an item: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 300);
    endfunction

    // receiver: ready and stall runs of random length, steady while calm
    initial
    begin : result_sink
        int hold;
        int r;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (calm)
                m_tready <= 1'b1;
            else if (m_tready)
            begin
                m_tready <= 1'b0;
                r = $urandom_range(0, 99);
                if (r < 70)
                    hold = $urandom_range(0, 2);
                else if (r < 93)
                    hold = $urandom_range(3, 15);
                else
                    hold = $urandom_range(40, 250);
            end
            else
            begin
                m_tready <= 1'b1;
                hold = $urandom_range(0, 30);
            end
        end
    end

    // offer one item and hold it until the block takes it
    task automatic send_item(input logic op, input logic [63:0] key, input logic [63:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {t, key};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (op == OP_QUERY)
            queries_sent++;
    endtask

    task automatic record(input logic [63:0] key, input logic [63:0] t);
        send_item(OP_RECORD, key, t);
    endtask

    // the key field is unused by a query, so it carries noise
    task automatic query(input logic [63:0] t);
        send_item(OP_QUERY, rand64(), t);
    endtask

    // hold off until every result is in, then let a trailing record finish
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        reg_writes++;
    endtask

    // many distinct sources in groups sharing one timestamp, with a query now and then:
    // fills the table, then evicts with ties on the oldest last-seen time
    task automatic fill_table(input int quota);
        int j;
        int n_rec;
        n_rec = 0;
        for (j = 0; j < quota; j++)
        begin
            if ($urandom_range(0, 9) == 0)
                query(now_ns);
            else
            begin
                record(rand64(), now_ns);
                n_rec++;
                if (n_rec % 8 == 0)
                    now_ns = now_ns + $urandom_range(1, 500);
            end
        end
    endtask

    // mostly bursts of failures on a few recurring sources, with queries, new sources,
    // out-of-order times and time jumps mixed in
    task automatic run_phase(input int quota);
        int          stop_at;
        int          r;
        int          k;
        int          j;
        logic [63:0] key;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                key = pool[$urandom_range(0, 15)];
                k = $urandom_range(1, 6);
                for (j = 0; j < k; j++)
                begin
                    now_ns = now_ns + $urandom_range(0, 200);
                    record(key, now_ns);
                end
            end
            else if (r < 58)
            begin
                now_ns = now_ns + $urandom_range(0, 1500);
                record(rand64(), now_ns);
            end
            else if (r < 64)
                record($urandom_range(0, 1) ? pool[$urandom_range(0, 15)] : rand64(), rand64());
            else if (r < 66)
            begin
                now_ns = rand64();
                record(pool[$urandom_range(0, 15)], now_ns);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    query(now_ns);
                else if (r < 85)
                    query(now_ns - $urandom_range(0, 3000));   // before first sighting: age wraps
                else
                    query(rand64());
            end
        end
    endtask

    initial
    begin : stimulus
        int i;
        int p;
        pool[0] = '0;
        pool[1] = ALL_ONES;
        for (i = 2; i < 16; i++)
            pool[i] = rand64();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, key and time extremes, age wrap, window and threshold limits
        query(64'd0);
        record(64'd0, 64'd0);
        record(ALL_ONES, ALL_ONES);
        query(64'd5);                       // counts of one stay under the reset threshold
        write_reg(REG_THRESHOLD, 64'd0);
        query(64'd0);
        query(ALL_ONES);                    // first entry too old, second exactly now
        query(ALL_ONES - 64'd1);            // second entry lies in the future: wraps
        write_reg(REG_WINDOW, ALL_ONES);
        query(64'd12345);
        write_reg(REG_WINDOW, 64'd0);
        query(64'd0);                       // age zero against a zero window
        query(64'd1);
        write_reg(REG_THRESHOLD, {32'd0, COUNT_MAX});
        query(64'd0);                       // nothing can exceed the largest threshold
        write_reg(REG_WINDOW, WINDOW_RESET);
        write_reg(REG_THRESHOLD, 64'd2);
        record(pool[2], 64'd10);
        record(pool[2], 64'd11);
        record(pool[3], 64'd20);
        record(pool[2], 64'd12);            // hit moves last-seen, count now three
        query(64'd13);

        // random phases, one register setting each; the table fills before phase two
        now_ns = 64'd1000;
        for (p = 0; p < 8; p++)
        begin
            if (p == 2)
                fill_table(300);
            write_reg(REG_WINDOW, win_set[p]);
            write_reg(REG_THRESHOLD, {32'd0, thr_set[p]});
            calm = (p == 3);
            run_phase(205);
        end
        calm = 1'b0;

        settle();
        $display("summary: %0d items (%0d queries), %0d register writes", items_sent,
                 queries_sent, reg_writes);
        $display("summary: %0d results checked, %0d reported a source", checked, detections);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pstl_pkg.sv
hw/rtl/pstl_ram.sv
hw/rtl/pstl_ctrl.sv
hw/rtl/pstl_dp.sv
hw/rtl/per_source_failure_tracker_lru_core.sv
tb/tb_pstl_checker.sv
tb/tb_per_source_failure_tracker_lru_core.sv
